FILE: hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Calibrated moving average package
// Shared types, item codes and widths for the calibrated moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int CFG_W          = 7;
  localparam int ACC_W          = 48;
  localparam int CNT_W          = 16;
  localparam int DIV_W          = 48;
  localparam int DIV_CNT_W      = $clog2(DIV_W);
  localparam int Q_SHIFT        = 24;

  localparam logic [2:0] KIND_FILTER    = 3'd0;
  localparam logic [2:0] KIND_CAL_START = 3'd1;
  localparam logic [2:0] KIND_CAL_SAMPLE = 3'd2;
  localparam logic [2:0] KIND_CAL_END   = 3'd3;
  localparam logic [2:0] KIND_CAL_LOAD  = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CAL_ZERO = 2'd1;
  localparam logic [1:0] STATUS_CNT_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]          kind;
    logic signed [15:0]  sample;
    logic signed [23:0]  calib_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  filtered;
    logic signed [23:0]  calibration_out;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISP,
    ST_QDIV,
    ST_WRITE,
    ST_MODW,
    ST_SUM,
    ST_MDIV,
    ST_CDIV,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/cma_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring divider that produces one quotient bit per cycle and reports the
// quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module cma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cma_pkg::div_req_t  req,
  output cma_pkg::div_rsp_t  rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [cma_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [cma_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [cma_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [cma_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [cma_pkg::DIV_W:0]       trial;
  logic [cma_pkg::DIV_W:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[cma_pkg::DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[cma_pkg::DIV_W]) begin
        rem_nxt = diff[cma_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[cma_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[cma_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[cma_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cma_pkg::DIV_CNT_W'(cma_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: hdl/calibrated_moving_average.sv
// ----------------------------------------------------------------------------
// Calibrated moving average
// Divides rotary samples by a calibration, keeps them in a ring store and
// reports the truncated mean of the first filter_length entries. Calibration
// items accumulate samples and divide the sum by their count.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   cma_pkg::in_item_t
//   out_      output     out_valid / out_ready cma_pkg::out_item_t
//   cfg_      input      cfg_valid / cfg_ready filter_length, 7 bits
//
// After reset the ring store is cleared with in_ready low.
// A filter transaction makes three passes of the shared divider, two when the
// calibration is zero, and walks the first filter_length ring entries.
// A calibration end makes one divider pass unless its count is zero; other kinds make none.
// A new transaction is taken while the previous result waits on out_ready.
// ----------------------------------------------------------------------------
module calibrated_moving_average #(
  parameter int MAX_LENGTH = cma_pkg::MAX_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cma_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cma_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cma_pkg::CFG_W-1:0] cfg_data
);

  localparam int POS_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W = 33 + POS_W;
  localparam int AW    = cma_pkg::ACC_W;
  localparam int DW    = cma_pkg::DIV_W;

  localparam logic signed [DW:0] Q_MAX_EXT   = (DW + 1)'(32'sh7FFFFFFF);
  localparam logic signed [DW:0] Q_MIN_EXT   = (DW + 1)'(32'sh80000000);
  localparam logic signed [DW:0] CAL_MAX_EXT = (DW + 1)'(24'sh7FFFFF);
  localparam logic signed [DW:0] CAL_MIN_EXT = (DW + 1)'(24'sh800000);

  cma_pkg::state_t             state_r, state_nxt;
  cma_pkg::in_item_t           item_r, item_nxt;
  cma_pkg::out_item_t          res_r, res_nxt;
  cma_pkg::out_item_t          out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [AW-1:0]        acc_r, acc_nxt;
  logic [cma_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [LEN_W-1:0]            idx_r, idx_nxt;
  logic signed [31:0]          q_r, q_nxt;
  logic                        sgn_r, sgn_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic                        pend_r, pend_nxt;

  logic [31:0]                 ring_mem [MAX_LENGTH];
  logic signed [31:0]          rd_data_r;
  logic                        mem_we;
  logic [POS_W-1:0]            mem_waddr;
  logic [31:0]                 mem_wdata;
  logic [POS_W-1:0]            mem_raddr;

  cma_pkg::div_req_t           div_req;
  cma_pkg::div_rsp_t           div_rsp;

  logic [31:0]                 cfg_ext;
  logic signed [16:0]          smp_ext;
  logic [16:0]                 smp_mag;
  logic [AW-1:0]               acc_mag;
  logic signed [AW:0]          smp_acc;
  logic signed [AW:0]          acc_sum;
  logic signed [SUM_W-1:0]     sum_add;
  logic [SUM_W-1:0]            sum_mag;
  logic signed [DW:0]          quot_s;
  logic                        out_free;

  function automatic logic signed [31:0] sat32(input logic signed [DW:0] v);
    if (v > Q_MAX_EXT) begin
      return 32'sh7FFFFFFF;
    end else if (v < Q_MIN_EXT) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [DW:0] v);
    if (v > CAL_MAX_EXT) begin
      return 24'sh7FFFFF;
    end else if (v < CAL_MIN_EXT) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  cma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == cma_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cfg_ext = 32'(cfg_data);
    if (cfg_ext == 32'd0) begin
      len_nxt = LEN_W'(1);
    end else if (cfg_ext > 32'(MAX_LENGTH)) begin
      len_nxt = LEN_W'(MAX_LENGTH);
    end else begin
      len_nxt = LEN_W'(cfg_ext);
    end
  end

  always_comb begin
    smp_ext = 17'(item_r.sample);
    smp_mag = smp_ext[16] ? 17'(-smp_ext) : 17'(smp_ext);
    acc_mag = acc_r[AW-1] ? (~acc_r + 1'b1) : acc_r;
    smp_acc = (AW + 1)'(item_r.sample) <<< 8;
    acc_sum = (AW + 1)'(acc_r) + smp_acc;
    sum_add = pend_r ? (sum_r + SUM_W'(rd_data_r)) : sum_r;
    sum_mag = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    quot_s  = {1'b0, div_rsp.quot};
    if (sgn_r) begin
      quot_s = -quot_s;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cma_pkg::ST_CLEAR: begin
        if (idx_r == LEN_W'(MAX_LENGTH - 1)) begin
          state_nxt = cma_pkg::ST_IDLE;
        end
      end
      cma_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cma_pkg::ST_DISP;
        end
      end
      cma_pkg::ST_DISP: begin
        unique case (item_r.kind)
          cma_pkg::KIND_FILTER: begin
            state_nxt = (acc_r == '0) ? cma_pkg::ST_WRITE : cma_pkg::ST_QDIV;
          end
          cma_pkg::KIND_CAL_END: begin
            state_nxt = (cnt_r == '0) ? cma_pkg::ST_DONE : cma_pkg::ST_CDIV;
          end
          default: begin
            state_nxt = cma_pkg::ST_DONE;
          end
        endcase
      end
      cma_pkg::ST_QDIV: begin
        if (div_rsp.done) begin
          state_nxt = cma_pkg::ST_WRITE;
        end
      end
      cma_pkg::ST_WRITE: begin
        state_nxt = cma_pkg::ST_MODW;
      end
      cma_pkg::ST_MODW: begin
        if (div_rsp.done) begin
          state_nxt = cma_pkg::ST_SUM;
        end
      end
      cma_pkg::ST_SUM: begin
        if (idx_r == len_r) begin
          state_nxt = cma_pkg::ST_MDIV;
        end
      end
      cma_pkg::ST_MDIV, cma_pkg::ST_CDIV: begin
        if (div_rsp.done) begin
          state_nxt = cma_pkg::ST_DONE;
        end
      end
      cma_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    sgn_nxt       = sgn_r;
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = q_r;
    mem_raddr     = idx_r[POS_W-1:0];
    div_req       = '0;

    unique case (state_r)
      cma_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[POS_W-1:0];
        mem_wdata = '0;
        idx_nxt   = idx_r + 1'b1;
      end
      cma_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      cma_pkg::ST_DISP: begin
        res_nxt = '0;
        unique case (item_r.kind)
          cma_pkg::KIND_FILTER: begin
            if (acc_r == '0) begin
              q_nxt          = '0;
              res_nxt.status = cma_pkg::STATUS_CAL_ZERO;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DW'({smp_mag, {cma_pkg::Q_SHIFT{1'b0}}});
              div_req.divisor  = DW'(acc_mag);
              sgn_nxt          = item_r.sample[15] ^ acc_r[AW-1];
            end
          end
          cma_pkg::KIND_CAL_START: begin
            acc_nxt = '0;
            cnt_nxt = '0;
          end
          cma_pkg::KIND_CAL_SAMPLE: begin
            if (acc_sum[AW] != acc_sum[AW-1]) begin
              acc_nxt = {acc_sum[AW], {(AW - 1){~acc_sum[AW]}}};
            end else begin
              acc_nxt = acc_sum[AW-1:0];
            end
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          cma_pkg::KIND_CAL_END: begin
            if (cnt_r == '0) begin
              acc_nxt        = '0;
              res_nxt.status = cma_pkg::STATUS_CNT_ZERO;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DW'(acc_mag);
              div_req.divisor  = DW'(cnt_r);
              sgn_nxt          = acc_r[AW-1];
            end
          end
          cma_pkg::KIND_CAL_LOAD: begin
            acc_nxt                 = AW'(item_r.calib_value);
            res_nxt.calibration_out = item_r.calib_value;
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      cma_pkg::ST_QDIV: begin
        if (div_rsp.done) begin
          q_nxt = sat32(quot_s);
        end
      end
      cma_pkg::ST_WRITE: begin
        mem_we           = 1'b1;
        div_req.start    = 1'b1;
        div_req.dividend = DW'({1'b0, pos_r} + 1'b1);
        div_req.divisor  = DW'(len_r);
      end
      cma_pkg::ST_MODW: begin
        if (div_rsp.done) begin
          pos_nxt  = div_rsp.rem[POS_W-1:0];
          idx_nxt  = '0;
          sum_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      cma_pkg::ST_SUM: begin
        sum_nxt = sum_add;
        if (idx_r != len_r) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt         = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = DW'(sum_mag);
          div_req.divisor  = DW'(len_r);
          sgn_nxt          = sum_add[SUM_W-1];
        end
      end
      cma_pkg::ST_MDIV: begin
        if (div_rsp.done) begin
          res_nxt.filtered = quot_s[31:0];
        end
      end
      cma_pkg::ST_CDIV: begin
        if (div_rsp.done) begin
          acc_nxt                 = AW'(sat24(quot_s));
          res_nxt.calibration_out = sat24(quot_s);
        end
      end
      cma_pkg::ST_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cma_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
      acc_r       <= AW'(256);
      cnt_r       <= '0;
      pos_r       <= '0;
      len_r       <= LEN_W'(MAX_LENGTH);
      idx_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      len_r       <= (cfg_valid && cfg_ready) ? len_nxt : len_r;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    q_r    <= q_nxt;
    sgn_r  <= sgn_nxt;
    sum_r  <= sum_nxt;
  end

endmodule
